/* hdl/ssg_pkg.sv */
// Shared constants and types for the sine sample generator.
`default_nettype none

package ssg_pkg;

  // Widths fixed by the register and field definitions
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 32;
  localparam int PROD_W  = IDX_W + CFG_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Default build parameters
  localparam int OUT_BITS_DEF   = 16;
  localparam int PHASE_BITS_DEF = 24;

  // Register reset values
  localparam logic [CFG_W-1:0] TONE_RESET = 20'd440;
  localparam logic [CFG_W-1:0] RATE_RESET = 20'd48000;

  // Register select (byte address bit 2)
  localparam logic REG_TONE = 1'b0;
  localparam logic REG_RATE = 1'b1;

  // Q1.30 one
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // sin(pi/2 * x) odd Taylor coefficients, Q2.30
  localparam logic [31:0] C1  = 32'd1686629713;
  localparam logic [31:0] C3  = 32'd693598668;
  localparam logic [31:0] C5  = 32'd85569306;
  localparam logic [31:0] C7  = 32'd5026995;
  localparam logic [31:0] C9  = 32'd172272;
  localparam logic [31:0] C11 = 32'd3864;

  localparam int HORNER_STEPS = 5;
  localparam logic [31:0] HORNER_COEF [HORNER_STEPS] = '{C9, C7, C5, C3, C1};

  // Values that ride along the polynomial cells
  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] x;
    logic [30:0] x2;
  } poly_ctx_t;

endpackage

`default_nettype wire

/* hdl/ssg_div_cell.sv */
// One restoring-division cell: one remainder step and one quotient bit per clock while en is high.
`default_nettype none

module ssg_div_cell #(
  parameter int SW = ssg_pkg::PROD_W + ssg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic [ssg_pkg::CFG_W-1:0]  rate,
  input  wire logic                       valid_in,
  input  wire logic [ssg_pkg::CFG_W-1:0]  rem_in,
  input  wire logic [SW-1:0]              sh_in,
  output logic                            valid_out,
  output logic [ssg_pkg::CFG_W-1:0]       rem_out,
  output logic [SW-1:0]                   sh_out
);

  logic [ssg_pkg::CFG_W:0]   trial;
  logic [ssg_pkg::CFG_W:0]   diff;
  logic                      ge;
  logic [ssg_pkg::CFG_W-1:0] rem_next;
  logic [SW-1:0]             sh_next;

  // Bring down the next dividend bit, subtract where it fits
  always_comb begin
    trial    = {rem_in, sh_in[SW-1]};
    diff     = trial - {1'b0, rate};
    ge       = (trial >= {1'b0, rate});
    rem_next = ge ? diff[ssg_pkg::CFG_W-1:0] : trial[ssg_pkg::CFG_W-1:0];
    sh_next  = {sh_in[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      sh_out  <= sh_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/ssg_horner_cell.sv */
// One Horner step of the quarter-wave polynomial: t = coef - (t * x2) >> 30.
`default_nettype none

module ssg_horner_cell #(
  parameter logic [31:0] COEF = ssg_pkg::C9
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               valid_in,
  input  wire logic [31:0]        t_in,
  input  wire ssg_pkg::poly_ctx_t ctx_in,
  output logic                    valid_out,
  output logic [31:0]             t_out,
  output ssg_pkg::poly_ctx_t      ctx_out
);

  logic [61:0] prod;
  logic [31:0] t_next;

  always_comb begin
    prod   = 62'(t_in) * 62'(ctx_in.x2);
    t_next = COEF - prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_out   <= t_next;
      ctx_out <= ctx_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/sine_sample_generator.sv */
// Top level of the sine sample generator: config port, division and polynomial pipeline.
//
// Usage
//   Input channel (index_valid / index_stall / sample_index) takes one sample
//   index per item; output channel (sine_valid / sine_stall / sine_value) returns
//   sin(2*pi*index*tone/rate) in signed Q1.(OUT_BITS-1), saturated to
//   +/-(2^(OUT_BITS-1)-1). A zero sample rate gives 0.
//   tone_hz (byte address 0) and sample_rate_hz (byte address 4) are written
//   over the APB port; write them only while no item is in flight.
// Throughput: one item per clock while the output is not stalled.
// Structure: after the product register comes a chain of restoring-division
//   cells: 52 cells reduce index*tone modulo the rate and PHASE_BITS further
//   cells scale the remainder to a fraction of a turn.
// Reset: synchronous rst empties the pipeline and restores tone 440 Hz and
//   sample rate 48000 Hz.
// Stall: while a result waits and sine_stall is high the whole pipeline holds
//   and index_stall is raised; with bubbles nothing is lost or repeated.
`default_nettype none

module sine_sample_generator #(
  parameter int OUT_BITS   = ssg_pkg::OUT_BITS_DEF,
  parameter int PHASE_BITS = ssg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ssg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ssg_pkg::DATA_W-1:0]  pwdata,
  output logic [ssg_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  // Input channel
  input  wire logic                        index_valid,
  output logic                             index_stall,
  input  wire logic [ssg_pkg::IDX_W-1:0]   sample_index,
  // Output channel
  output logic                             sine_valid,
  input  wire logic                        sine_stall,
  output logic signed [OUT_BITS-1:0]       sine_value
);

  localparam int NDIV = ssg_pkg::PROD_W + PHASE_BITS;  // division cells
  localparam int SW   = NDIV;                          // dividend/quotient word
  localparam int NH   = ssg_pkg::HORNER_STEPS;
  localparam int FR   = OUT_BITS - 1;                  // output fraction bits
  localparam int SH   = (FR <= 30) ? (30 - FR) : 0;
  localparam logic [32:0] RND  = (SH > 0) ? (33'd1 << (SH - 1)) : 33'd0;
  localparam logic [32:0] MAXV = (33'd1 << FR) - 33'd1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ssg_pkg::CFG_W-1:0] tone_hz;
  logic [ssg_pkg::CFG_W-1:0] sample_rate_hz;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_hz        <= ssg_pkg::TONE_RESET;
      sample_rate_hz <= ssg_pkg::RATE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        ssg_pkg::REG_TONE: tone_hz        <= pwdata[ssg_pkg::CFG_W-1:0];
        ssg_pkg::REG_RATE: sample_rate_hz <= pwdata[ssg_pkg::CFG_W-1:0];
        default:           tone_hz        <= tone_hz;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ssg_pkg::REG_TONE: prdata = ssg_pkg::DATA_W'(tone_hz);
      ssg_pkg::REG_RATE: prdata = ssg_pkg::DATA_W'(sample_rate_hz);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless a result is held
  // ---------------------------------------------------------------------------
  logic en;

  assign en          = !(sine_valid && sine_stall);
  assign index_stall = !en;

  // ---------------------------------------------------------------------------
  // Product index * tone
  // ---------------------------------------------------------------------------
  logic                        prod_valid;
  logic [ssg_pkg::PROD_W-1:0]  prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= index_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= ssg_pkg::PROD_W'(sample_index) * ssg_pkg::PROD_W'(tone_hz);
    end
  end

  // ---------------------------------------------------------------------------
  // Division chain: long division of prod * 2^PHASE_BITS by the rate. After
  // the first 52 cells the remainder is prod mod rate; the last PHASE_BITS
  // quotient bits are the phase as a fraction of a turn.
  // ---------------------------------------------------------------------------
  logic                      div_v   [NDIV+1];
  logic [ssg_pkg::CFG_W-1:0] div_rem [NDIV+1];
  logic [SW-1:0]             div_sh  [NDIV+1];

  assign div_v[0]   = prod_valid;
  assign div_rem[0] = '0;
  assign div_sh[0]  = SW'(prod) << PHASE_BITS;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    ssg_div_cell #(
      .SW (SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .rate      (sample_rate_hz),
      .valid_in  (div_v[i]),
      .rem_in    (div_rem[i]),
      .sh_in     (div_sh[i]),
      .valid_out (div_v[i+1]),
      .rem_out   (div_rem[i+1]),
      .sh_out    (div_sh[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Quarter-wave fold
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] ph;
  logic [31:0]           turn;
  logic [30:0]           r_ext;
  logic                  fold_valid;
  logic [1:0]            fold_quad;
  logic [30:0]           fold_x;

  always_comb begin
    ph    = div_sh[NDIV][PHASE_BITS-1:0];
    turn  = 32'(ph) << (32 - PHASE_BITS);
    r_ext = {1'b0, turn[29:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (en) begin
      fold_valid <= div_v[NDIV];
    end
  end

  // Mirror quadrants 1 and 3 onto the rising quarter
  always_ff @(posedge clk) begin
    if (en) begin
      fold_quad <= turn[31:30];
      fold_x    <= turn[30] ? (ssg_pkg::Q30_ONE - r_ext) : r_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Square of x, then the Horner cells
  // ---------------------------------------------------------------------------
  logic [60:0] sq_prod;
  logic        hv  [NH+1];
  logic [31:0] ht  [NH+1];
  ssg_pkg::poly_ctx_t hctx [NH+1];

  assign sq_prod = 61'(fold_x) * 61'(fold_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else if (en) begin
      hv[0] <= fold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ht[0]        <= ssg_pkg::C11;
      hctx[0].quad <= fold_quad;
      hctx[0].x    <= fold_x;
      hctx[0].x2   <= sq_prod[60:30];
    end
  end

  for (genvar j = 0; j < NH; j++) begin : g_horner
    ssg_horner_cell #(
      .COEF (ssg_pkg::HORNER_COEF[j])
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (hv[j]),
      .t_in      (ht[j]),
      .ctx_in    (hctx[j]),
      .valid_out (hv[j+1]),
      .t_out     (ht[j+1]),
      .ctx_out   (hctx[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Final multiply by x
  // ---------------------------------------------------------------------------
  logic [61:0] fin_prod;
  logic        fin_valid;
  logic [1:0]  fin_quad;
  logic [31:0] fin_m;

  assign fin_prod = 62'(ht[NH]) * 62'(hctx[NH].x);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= hv[NH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_quad <= hctx[NH].quad;
      fin_m    <= fin_prod[61:30];
    end
  end

  // ---------------------------------------------------------------------------
  // Round half up to the output fraction (or widen for a 32-bit output)
  // ---------------------------------------------------------------------------
  logic [32:0] rnd_next;
  logic        rnd_valid;
  logic [1:0]  rnd_quad;
  logic [32:0] rnd_m;

  always_comb begin
    if (FR <= 30) begin
      rnd_next = (33'(fin_m) + RND) >> SH;
    end else begin
      rnd_next = 33'(fin_m) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_quad <= fin_quad;
      rnd_m    <= rnd_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate, apply the sign of the lower half-turn, output register
  // ---------------------------------------------------------------------------
  logic [32:0]         sat_m;
  logic [OUT_BITS-1:0] mag;
  logic [OUT_BITS-1:0] value_next;

  always_comb begin
    sat_m = (rnd_m > MAXV) ? MAXV : rnd_m;
    mag   = sat_m[OUT_BITS-1:0];
    if (sample_rate_hz == '0) begin
      value_next = '0;
    end else if (rnd_quad[1]) begin
      value_next = -mag;
    end else begin
      value_next = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_valid <= 1'b0;
    end else if (en) begin
      sine_valid <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine_value <= value_next;
    end
  end

endmodule

`default_nettype wire
